// ===== src/list_definition_syntax_checker_assert.svh =====
// Assertion macros for the list definition syntax checker.
`ifndef LIST_DEFINITION_SYNTAX_CHECKER_ASSERT_SVH
`define LIST_DEFINITION_SYNTAX_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property while out of reset.
`define LDSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define LDSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LDSC_ASSERT(lbl, clk, rst, prop, msg)
`define LDSC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/ldsc_pkg.sv =====
package ldsc_pkg;

   typedef logic [7:0] char_type;
   typedef logic [2:0] stage_type;

   localparam stage_type STAGE_NONE    = 3'd0;
   localparam stage_type STAGE_KEYWORD = 3'd1;
   localparam stage_type STAGE_NAME    = 3'd2;
   localparam stage_type STAGE_EQUALS  = 3'd3;
   localparam stage_type STAGE_BRACKET = 3'd4;
   localparam stage_type STAGE_ELEMENT = 3'd5;
   localparam stage_type STAGE_CLOSE   = 3'd6;
   localparam stage_type STAGE_EARLY   = 3'd7;

   localparam char_type CH_D     = 8'h64;
   localparam char_type CH_E     = 8'h65;
   localparam char_type CH_F     = 8'h66;
   localparam char_type CH_L     = 8'h6C;
   localparam char_type CH_EQ    = 8'h3D;
   localparam char_type CH_OPEN  = 8'h5B;
   localparam char_type CH_COMMA = 8'h2C;
   localparam char_type CH_CLOSE = 8'h5D;
   localparam char_type CH_SEMI  = 8'h3B;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_CR    = 8'h0D;

   function automatic logic is_ws(input char_type c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_digit(input char_type c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input char_type c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

endpackage

// ===== src/list_definition_syntax_checker.sv =====
// Checks a line  ws* defl ws* NAME ws* = ws* [ ws* {NUM ws* , ws*}* (NUM ws* ,? ws*)? ] ws* ;
// fed one byte per item, and gives one result (verdict and failing stage) for the item
// marked last. One byte is taken every clock; the byte sits in an input register while
// the parse state advances, and the result is registered from the last byte's parse step.
// The one-state-per-byte parse loop sets the rate; a result waiting at the output holds up
// only a following last byte.
`include "list_definition_syntax_checker_assert.svh"

module list_definition_syntax_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ldsc_pkg::char_type   req_ch,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_accepted,
   output ldsc_pkg::stage_type  rsp_fail_stage
);
   import ldsc_pkg::*;

   typedef enum logic [3:0] {
      PH_KW_WS, PH_KW_D, PH_KW_DE, PH_KW_DEF, PH_NAME_WS, PH_NAME, PH_EQ_WS,
      PH_BR_WS, PH_ELEM, PH_NUM, PH_AFTNUM, PH_SEMI, PH_ACCEPT, PH_FAIL
   } phase_type;

   phase_type phase_ff, phase_in;
   stage_type fail_ff, fail_in;
   phase_type adv_phase;
   stage_type adv_fail;

   logic      in_valid_ff, in_valid_in;
   char_type  in_ch_ff;
   logic      in_last_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_accepted_ff, rsp_accepted_in;
   stage_type rsp_fail_ff, rsp_fail_in;

   logic      req_fire;
   logic      parse_fire;
   logic      verdict;

   // A last byte cannot move on while the previous verdict is still held.
   assign parse_fire = in_valid_ff && !(in_last_ff && rsp_valid_ff && rsp_stall);
   assign verdict    = parse_fire && in_last_ff;
   assign req_stall  = in_valid_ff && !parse_fire;
   assign req_fire   = req_valid && !req_stall;

   always_comb begin
      adv_phase = phase_ff;
      adv_fail  = fail_ff;
      case (phase_ff)
         PH_KW_WS: begin
            if (!is_ws(in_ch_ff)) begin
               if (in_ch_ff == CH_D) adv_phase = PH_KW_D;
               else begin adv_phase = PH_FAIL; adv_fail = STAGE_KEYWORD; end
            end
         end
         PH_KW_D: begin
            if (in_ch_ff == CH_E) adv_phase = PH_KW_DE;
            else begin adv_phase = PH_FAIL; adv_fail = STAGE_KEYWORD; end
         end
         PH_KW_DE: begin
            if (in_ch_ff == CH_F) adv_phase = PH_KW_DEF;
            else begin adv_phase = PH_FAIL; adv_fail = STAGE_KEYWORD; end
         end
         PH_KW_DEF: begin
            if (in_ch_ff == CH_L) adv_phase = PH_NAME_WS;
            else begin adv_phase = PH_FAIL; adv_fail = STAGE_KEYWORD; end
         end
         PH_NAME_WS: begin
            if (!is_ws(in_ch_ff)) begin
               if (is_alpha(in_ch_ff)) adv_phase = PH_NAME;
               else begin adv_phase = PH_FAIL; adv_fail = STAGE_NAME; end
            end
         end
         PH_NAME: begin
            if (!(is_alpha(in_ch_ff) || is_digit(in_ch_ff))) begin
               if (is_ws(in_ch_ff)) adv_phase = PH_EQ_WS;
               else if (in_ch_ff == CH_EQ) adv_phase = PH_BR_WS;
               else begin adv_phase = PH_FAIL; adv_fail = STAGE_EQUALS; end
            end
         end
         PH_EQ_WS: begin
            if (!is_ws(in_ch_ff)) begin
               if (in_ch_ff == CH_EQ) adv_phase = PH_BR_WS;
               else begin adv_phase = PH_FAIL; adv_fail = STAGE_EQUALS; end
            end
         end
         PH_BR_WS: begin
            if (!is_ws(in_ch_ff)) begin
               if (in_ch_ff == CH_OPEN) adv_phase = PH_ELEM;
               else begin adv_phase = PH_FAIL; adv_fail = STAGE_BRACKET; end
            end
         end
         PH_ELEM: begin
            if (!is_ws(in_ch_ff)) begin
               if (is_digit(in_ch_ff)) adv_phase = PH_NUM;
               else if (in_ch_ff == CH_CLOSE) adv_phase = PH_SEMI;
               else begin adv_phase = PH_FAIL; adv_fail = STAGE_ELEMENT; end
            end
         end
         PH_NUM: begin
            if (!is_digit(in_ch_ff)) begin
               if (is_ws(in_ch_ff)) adv_phase = PH_AFTNUM;
               else if (in_ch_ff == CH_COMMA) adv_phase = PH_ELEM;
               else if (in_ch_ff == CH_CLOSE) adv_phase = PH_SEMI;
               else begin adv_phase = PH_FAIL; adv_fail = STAGE_ELEMENT; end
            end
         end
         PH_AFTNUM: begin
            if (!is_ws(in_ch_ff)) begin
               if (in_ch_ff == CH_COMMA) adv_phase = PH_ELEM;
               else if (in_ch_ff == CH_CLOSE) adv_phase = PH_SEMI;
               else begin adv_phase = PH_FAIL; adv_fail = STAGE_ELEMENT; end
            end
         end
         PH_SEMI: begin
            if (!is_ws(in_ch_ff)) begin
               if (in_ch_ff == CH_SEMI) adv_phase = PH_ACCEPT;
               else begin adv_phase = PH_FAIL; adv_fail = STAGE_CLOSE; end
            end
         end
         PH_ACCEPT: ;
         PH_FAIL: ;
         default: begin
            adv_phase = PH_FAIL;
            adv_fail  = STAGE_EARLY;
         end
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      fail_in         = fail_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_fail_in     = rsp_fail_ff;
      if (parse_fire) begin
         phase_in = adv_phase;
         fail_in  = adv_fail;
      end
      if (verdict) begin
         // give the verdict, then start a fresh line
         rsp_valid_in    = 1'b1;
         rsp_accepted_in = (adv_phase == PH_ACCEPT);
         if (adv_phase == PH_ACCEPT) rsp_fail_in = STAGE_NONE;
         else if (adv_phase == PH_FAIL) rsp_fail_in = adv_fail;
         else rsp_fail_in = STAGE_EARLY;
         phase_in = PH_KW_WS;
         fail_in  = STAGE_NONE;
      end
      in_valid_in = req_fire ? 1'b1 : (in_valid_ff && !parse_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_KW_WS;
         fail_ff      <= STAGE_NONE;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fail_ff      <= fail_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ch_ff   <= req_ch;
         in_last_ff <= req_last;
      end
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_fail_ff     <= rsp_fail_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_fail_stage = rsp_fail_ff;

   `LDSC_ASSERT(a_accept_no_stage, clock, reset,
      (rsp_valid_ff && rsp_accepted_ff) |-> (rsp_fail_ff == STAGE_NONE),
      "accepted verdict carries a failing stage")
   `LDSC_ASSERT(a_line_restart, clock, reset,
      verdict |=> (phase_ff == PH_KW_WS && fail_ff == STAGE_NONE),
      "parse state not cleared after verdict")
   `LDSC_ASSERT(a_fail_has_stage, clock, reset,
      (phase_ff == PH_FAIL) |-> (fail_ff != STAGE_NONE),
      "rejection without a failing stage")
   `LDSC_ASSERT(a_stage_only_on_fail, clock, reset,
      (phase_ff != PH_FAIL) |-> (fail_ff == STAGE_NONE),
      "failing stage recorded without rejection")
   `LDSC_ASSERT_ALWAYS(a_reset_clears, clock,
      $past(reset) |-> (!rsp_valid_ff && !in_valid_ff),
      "valid flags not cleared by reset")

endmodule

// ===== tb/sv/list_definition_syntax_checker_tb.sv =====
`timescale 1ns / 100ps

module list_definition_syntax_checker_tb;
   import ldsc_pkg::*;

   typedef enum logic [3:0] {
      SCAN_LEAD_WS, SCAN_D, SCAN_DE, SCAN_DEF, SCAN_NAME_WS, SCAN_NAME, SCAN_EQ_WS,
      SCAN_OPEN_WS, SCAN_ELEM, SCAN_NUM, SCAN_AFTER_NUM, SCAN_SEMI, SCAN_DONE, SCAN_REJECTED
   } scan_state_type;

   typedef struct packed {
      logic      accepted;
      stage_type fail_stage;
   } verdict_type;

   localparam int RANDOM_BYTES = 1400;
   localparam int TAIL_BYTES   = 300;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   char_type  req_ch;
   logic      req_last;
   logic      rsp_valid;
   logic      rsp_stall;
   logic      rsp_accepted;
   stage_type rsp_fail_stage;

   scan_state_type scan_state;
   stage_type      rejected_at;
   verdict_type    pending_verdicts[$];
   char_type       line_buf[$];
   int             error_count = 0;
   int             bytes_sent = 0;
   bit             sender_idles = 1'b0;
   bit             quiet_run = 1'b0;

   list_definition_syntax_checker dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_accepted   (rsp_accepted),
      .rsp_fail_stage (rsp_fail_stage)
   );

   always #5 clock = ~clock;

   function automatic bit is_space(char_type c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit is_numeral(char_type c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(char_type c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   task automatic reject_line(stage_type stage);
      scan_state  = SCAN_REJECTED;
      rejected_at = stage;
   endtask

   // Advance the parse by one byte; on the final byte queue the verdict and restart.
   task automatic scan_byte(char_type c, logic last);
      verdict_type v;
      case (scan_state)
         SCAN_LEAD_WS: begin
            if (!is_space(c)) begin
               if (c == CH_D) scan_state = SCAN_D;
               else reject_line(STAGE_KEYWORD);
            end
         end
         SCAN_D:   if (c == CH_E) scan_state = SCAN_DE;  else reject_line(STAGE_KEYWORD);
         SCAN_DE:  if (c == CH_F) scan_state = SCAN_DEF; else reject_line(STAGE_KEYWORD);
         SCAN_DEF: if (c == CH_L) scan_state = SCAN_NAME_WS; else reject_line(STAGE_KEYWORD);
         SCAN_NAME_WS: begin
            if (!is_space(c)) begin
               if (is_letter(c)) scan_state = SCAN_NAME;
               else reject_line(STAGE_NAME);
            end
         end
         SCAN_NAME: begin
            if (!is_letter(c) && !is_numeral(c)) begin
               if (is_space(c)) scan_state = SCAN_EQ_WS;
               else if (c == CH_EQ) scan_state = SCAN_OPEN_WS;
               else reject_line(STAGE_EQUALS);
            end
         end
         SCAN_EQ_WS: begin
            if (!is_space(c)) begin
               if (c == CH_EQ) scan_state = SCAN_OPEN_WS;
               else reject_line(STAGE_EQUALS);
            end
         end
         SCAN_OPEN_WS: begin
            if (!is_space(c)) begin
               if (c == CH_OPEN) scan_state = SCAN_ELEM;
               else reject_line(STAGE_BRACKET);
            end
         end
         SCAN_ELEM: begin
            if (!is_space(c)) begin
               if (is_numeral(c)) scan_state = SCAN_NUM;
               else if (c == CH_CLOSE) scan_state = SCAN_SEMI;
               else reject_line(STAGE_ELEMENT);
            end
         end
         SCAN_NUM: begin
            if (!is_numeral(c)) begin
               if (is_space(c)) scan_state = SCAN_AFTER_NUM;
               else if (c == CH_COMMA) scan_state = SCAN_ELEM;
               else if (c == CH_CLOSE) scan_state = SCAN_SEMI;
               else reject_line(STAGE_ELEMENT);
            end
         end
         SCAN_AFTER_NUM: begin
            if (!is_space(c)) begin
               if (c == CH_COMMA) scan_state = SCAN_ELEM;
               else if (c == CH_CLOSE) scan_state = SCAN_SEMI;
               else reject_line(STAGE_ELEMENT);
            end
         end
         SCAN_SEMI: begin
            if (!is_space(c)) begin
               if (c == CH_SEMI) scan_state = SCAN_DONE;
               else reject_line(STAGE_CLOSE);
            end
         end
         SCAN_DONE, SCAN_REJECTED: ;
         default: reject_line(STAGE_EARLY);
      endcase
      if (last) begin
         if (scan_state == SCAN_DONE) v = '{accepted: 1'b1, fail_stage: STAGE_NONE};
         else if (scan_state == SCAN_REJECTED) v = '{accepted: 1'b0, fail_stage: rejected_at};
         else v = '{accepted: 1'b0, fail_stage: STAGE_EARLY};
         pending_verdicts.push_back(v);
         scan_state  = SCAN_LEAD_WS;
         rejected_at = STAGE_NONE;
      end
   endtask

   // Drive one item at the falling edge and hold it until the block takes it.
   task automatic send_byte(char_type c, logic last);
      int gap;
      if (sender_idles && !quiet_run && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_ch    <= c;
      req_last  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scan_byte(c, last);
      bytes_sent++;
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic add_ws(int most);
      int n;
      n = $urandom_range(0, most);
      repeat (n) begin
         if ($urandom_range(0, 2) == 0) line_buf.push_back(CH_SPACE);
         else line_buf.push_back(char_type'($urandom_range(CH_TAB, CH_CR)));
      end
   endtask

   task automatic add_alnum(bit letter_only);
      int pick;
      pick = $urandom_range(0, letter_only ? 1 : 2);
      case (pick)
         0: line_buf.push_back(char_type'($urandom_range("a", "z")));
         1: line_buf.push_back(char_type'($urandom_range("A", "Z")));
         default: line_buf.push_back(char_type'($urandom_range("0", "9")));
      endcase
   endtask

   task automatic build_good_line();
      int elems;
      line_buf.delete();
      add_ws(2);
      add_text("defl");
      add_ws(2);
      add_alnum(1'b1);
      repeat ($urandom_range(0, 5)) add_alnum(1'b0);
      add_ws(2);
      line_buf.push_back(CH_EQ);
      add_ws(2);
      line_buf.push_back(CH_OPEN);
      add_ws(1);
      elems = $urandom_range(0, 4);
      for (int e = 0; e < elems; e++) begin
         repeat ($urandom_range(1, 3))
            line_buf.push_back(char_type'($urandom_range("0", "9")));
         add_ws(1);
         // keep a trailing comma now and then
         if (e < elems - 1 || $urandom_range(0, 3) == 0) begin
            line_buf.push_back(CH_COMMA);
            add_ws(1);
         end
      end
      line_buf.push_back(CH_CLOSE);
      add_ws(2);
      line_buf.push_back(CH_SEMI);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) line_buf.push_back(char_type'($urandom_range(0, 255)));
   endtask

   // Mostly well-formed lines; the rest are corrupted, cut short or pure noise.
   task automatic build_random_line();
      int pos;
      build_good_line();
      case ($urandom_range(0, 9))
         6: begin
            pos = $urandom_range(0, line_buf.size() - 1);
            line_buf[pos] = char_type'($urandom_range(0, 255));
         end
         7: begin
            pos = $urandom_range(1, line_buf.size());
            while (line_buf.size() > pos) void'(line_buf.pop_back());
         end
         8: begin
            pos = $urandom_range(0, line_buf.size() - 1);
            line_buf.insert(pos, char_type'($urandom_range(0, 255)));
         end
         9: begin
            line_buf.delete();
            repeat ($urandom_range(1, 12))
               line_buf.push_back(char_type'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endtask

   task automatic directed_line(string s);
      line_buf.delete();
      add_text(s);
      send_line();
   endtask

   task automatic test_directed_lines();
      sender_idles = 1'b1;
      directed_line("x");
      directed_line("d");
      directed_line("defl1");
      directed_line("defla!");
      directed_line("defla (");
      directed_line("defla=(");
      directed_line("defla=[x");
      directed_line("defla=[1x");
      directed_line("defla=[1 x");
      directed_line("defla=[]x");
      directed_line("defla=[]");
      directed_line("defla=[];");
      directed_line("deflZ9=[1,];");
      // every whitespace code, then junk after the semicolon
      line_buf.delete();
      line_buf.push_back(CH_SPACE);
      for (int w = CH_TAB; w <= CH_CR; w++) line_buf.push_back(char_type'(w));
      add_text("defl Zz9 = [ 0 , 99 ] ; ");
      line_buf.push_back(8'hFF);
      send_line();
      // NUL inside the keyword, and a high byte in the name
      line_buf.delete();
      add_text("de");
      line_buf.push_back(8'h00);
      send_line();
      line_buf.delete();
      add_text("defla");
      line_buf.push_back(8'h80);
      send_line();
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_random_lines();
      while (bytes_sent < RANDOM_BYTES) begin
         sender_idles = $urandom_range(0, 2) != 0;
         build_random_line();
         send_line();
      end
   endtask

   task automatic test_back_to_back();
      int start;
      quiet_run = 1'b1;
      start = bytes_sent;
      while (bytes_sent - start < TAIL_BYTES) begin
         build_random_line();
         send_line();
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected result: accepted %0d, fail_stage %0d",
                   rsp_accepted, rsp_fail_stage);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0d, actual %0d", want.accepted, rsp_accepted);
               error_count++;
            end
            if (rsp_fail_stage !== want.fail_stage) begin
               $error("fail_stage: expected %0d, actual %0d", want.fail_stage,
                      rsp_fail_stage);
               error_count++;
            end
         end
      end
   end

   // Result-side back-pressure: bursts of stall, with quiet stretches between.
   initial begin
      int burst;
      bit stall_window;
      burst = 0;
      stall_window = 1'b1;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) == 0) stall_window = !stall_window;
         if (quiet_run) begin
            rsp_stall <= 1'b0;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (stall_window && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(1, 6) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_ch    = '0;
      req_last  = 1'b0;
      scan_state  = SCAN_LEAD_WS;
      rejected_at = STAGE_NONE;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_directed_lines();
      test_random_lines();
      test_back_to_back();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
